>>> rtl/core/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types, codes and defaults of the timestamp match buffer.
// ----------------------------------------------------------------------------
package tmb_pkg;

  localparam int unsigned DEPTH_DEF        = 128;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  localparam int unsigned STAMP_BITS    = 64;
  localparam int unsigned LIMIT_BITS    = 8;
  localparam int unsigned INTERVAL_BITS = 32;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  localparam logic [LIMIT_BITS-1:0]    MAX_ENTRIES_RST = 8'd100;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RST    = 32'd40000;

  // Register index as decoded from paddr[2].
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_INTERVAL    = 1'b1;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [LIMIT_BITS-1:0]    max_entries;
    logic [INTERVAL_BITS-1:0] match_interval_us;
  } cfg_t;

endpackage

>>> rtl/core/tmb_ram.sv
// ----------------------------------------------------------------------------
// tmb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/tmb_regs.sv
// ----------------------------------------------------------------------------
// tmb_regs
// APB configuration registers: entry limit and match interval.
// ----------------------------------------------------------------------------
module tmb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tmb_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [tmb_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [tmb_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output tmb_pkg::cfg_t                      cfg_o
);

  logic [tmb_pkg::LIMIT_BITS-1:0]    max_entries_q, max_entries_d;
  logic [tmb_pkg::INTERVAL_BITS-1:0] interval_q, interval_d;
  logic                              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    max_entries_d = max_entries_q;
    interval_d    = interval_q;
    if (wr_en) begin
      unique case (paddr[2])
        tmb_pkg::REG_MAX_ENTRIES: max_entries_d = pwdata[tmb_pkg::LIMIT_BITS-1:0];
        tmb_pkg::REG_INTERVAL:    interval_d    = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= tmb_pkg::MAX_ENTRIES_RST;
      interval_q    <= tmb_pkg::INTERVAL_RST;
    end else begin
      max_entries_q <= max_entries_d;
      interval_q    <= interval_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      tmb_pkg::REG_MAX_ENTRIES: prdata = {{(tmb_pkg::APB_DATA_BITS - tmb_pkg::LIMIT_BITS){1'b0}},
                                          max_entries_q};
      tmb_pkg::REG_INTERVAL:    prdata = interval_q;
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.max_entries       = max_entries_q;
  assign cfg_o.match_interval_us = interval_q;

endmodule

>>> rtl/core/tmb_ctrl.sv
// ----------------------------------------------------------------------------
// tmb_ctrl
// Ring pointers, push handling, query scan sequencer and result register.
// ----------------------------------------------------------------------------
module tmb_ctrl #(
  parameter int unsigned DEPTH        = tmb_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = tmb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmb_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [tmb_pkg::STAMP_BITS-1:0]    stamp_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [tmb_pkg::STAMP_BITS-1:0]    match_stamp_us_o,
  output logic [PAYLOAD_BITS-1:0]           payload_out_o,
  output logic                              mem_we_o,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_o,
  input  logic [tmb_pkg::STAMP_BITS-1:0]    rd_stamp_i,
  input  logic [PAYLOAD_BITS-1:0]           rd_payload_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > tmb_pkg::LIMIT_BITS) ? CW : tmb_pkg::LIMIT_BITS) + 1;
  localparam int unsigned SW   = tmb_pkg::STAMP_BITS;

  localparam logic [AW:0]     DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]   LAST_IX = AW'(DEPTH - 1);
  localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  tmb_pkg::state_e state_q, state_d;

  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [SW-1:0]           target_q, target_d;
  logic                    popped_q, popped_d;
  logic                    found_q, found_d;
  logic [SW-1:0]           last_stamp_q, last_stamp_d;
  logic [PAYLOAD_BITS-1:0] last_payload_q, last_payload_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q, out_found_d;
  logic [SW-1:0]           out_stamp_q, out_stamp_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;

  logic            accept;
  logic            slot_free;
  logic            stale;
  logic [AW-1:0]   head_inc;
  logic [AW:0]     tail_sum;
  logic [AW-1:0]   tail_ix;
  logic [CMPW-1:0] max_x;
  logic [CMPW-1:0] limit_x;
  logic [CMPW-1:0] count_inc_x;
  logic [SW-1:0]   lag;
  logic            lag_ok;

  assign accept    = in_valid_i & in_ready_o;
  assign slot_free = ~out_valid_q | out_ready_i;
  assign stale     = rd_stamp_i < target_q;
  assign head_inc  = (head_q == LAST_IX) ? '0 : head_q + AW'(1);
  assign tail_sum  = {1'b0, head_q} + (AW + 1)'(count_q);
  assign tail_ix   = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];

  // The limit saturates at the store depth.
  assign max_x       = CMPW'(cfg_i.max_entries);
  assign limit_x     = (max_x > DEPTH_X) ? DEPTH_X : max_x;
  assign count_inc_x = CMPW'(count_q) + CMPW'(1);

  assign lag    = target_q - last_stamp_q;
  assign lag_ok = lag <= {{(SW - tmb_pkg::INTERVAL_BITS){1'b0}}, cfg_i.match_interval_us};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmb_pkg::ST_IDLE: begin
        if (accept && cmd_i == tmb_pkg::CMD_QUERY) begin
          state_d = (count_q == '0) ? tmb_pkg::ST_FIN : tmb_pkg::ST_SCAN;
        end
      end
      tmb_pkg::ST_SCAN: begin
        if (!stale || count_q == CW'(1)) begin
          state_d = tmb_pkg::ST_FIN;
        end
      end
      tmb_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = tmb_pkg::ST_IDLE;
        end
      end
      default: state_d = tmb_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready_o     = (state_q == tmb_pkg::ST_IDLE);
    head_d         = head_q;
    count_d        = count_q;
    target_d       = target_q;
    popped_d       = popped_q;
    found_d        = found_q;
    last_stamp_d   = last_stamp_q;
    last_payload_d = last_payload_q;
    mem_we_o       = 1'b0;
    mem_waddr_o    = tail_ix;
    out_valid_d    = out_valid_q & ~out_ready_i;
    out_found_d    = out_found_q;
    out_stamp_d    = out_stamp_q;
    out_payload_d  = out_payload_q;

    unique case (state_q)
      tmb_pkg::ST_IDLE: begin
        if (accept && cmd_i == tmb_pkg::CMD_PUSH) begin
          mem_we_o = 1'b1;
          if (count_q == DEPTH_C) begin
            // Full store: the new beat overwrites the oldest slot.
            mem_waddr_o = head_q;
            head_d      = head_inc;
          end else if (count_inc_x > limit_x) begin
            head_d = head_inc;
          end else begin
            count_d = count_q + CW'(1);
          end
        end else if (accept) begin
          target_d       = stamp_us_i;
          popped_d       = 1'b0;
          found_d        = 1'b0;
          last_stamp_d   = '0;
          last_payload_d = '0;
        end
      end
      tmb_pkg::ST_SCAN: begin
        last_stamp_d   = rd_stamp_i;
        last_payload_d = rd_payload_i;
        if (stale) begin
          head_d   = head_inc;
          count_d  = count_q - CW'(1);
          popped_d = 1'b1;
        end else begin
          found_d = 1'b1;
        end
      end
      tmb_pkg::ST_FIN: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_found_d   = found_q | (popped_q & lag_ok);
          out_stamp_d   = last_stamp_q;
          out_payload_d = last_payload_q;
        end
      end
      default: ;
    endcase

    // The head entry is always prefetched, so a scan sees one entry per cycle.
    mem_raddr_o = head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmb_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      popped_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      popped_q    <= popped_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q       <= target_d;
    last_stamp_q   <= last_stamp_d;
    last_payload_q <= last_payload_d;
    out_found_q    <= out_found_d;
    out_stamp_q    <= out_stamp_d;
    out_payload_q  <= out_payload_d;
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = out_found_q;
  assign match_stamp_us_o = out_stamp_q;
  assign payload_out_o    = out_payload_q;

endmodule

>>> rtl/core/timestamp_match_buffer.sv
// Push: one beat per cycle while no query runs, taken in the cycle it arrives;
// it produces no result. Query: holds off further beats while it runs; the
// scan reads one entry per cycle from the stamp memory; the result is registered.
// Reset: pointers and count clear at once and configuration returns to its defaults;
// the memories are not cleared, and only entries inside the count are ever read.
// ----------------------------------------------------------------------------
// timestamp_match_buffer
// Bounded ring of timestamped records with lookup of the first record at or
// after a target time, or else of the last older one within the match interval.
// ----------------------------------------------------------------------------
module timestamp_match_buffer #(
  parameter int unsigned DEPTH        = tmb_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = tmb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmb_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tmb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tmb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [tmb_pkg::STAMP_BITS-1:0]    stamp_us_i,
  input  logic [PAYLOAD_BITS-1:0]           payload_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [tmb_pkg::STAMP_BITS-1:0]    match_stamp_us_o,
  output logic [PAYLOAD_BITS-1:0]           payload_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  tmb_pkg::cfg_t                 cfg;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [AW-1:0]                 mem_raddr;
  logic [tmb_pkg::STAMP_BITS-1:0] rd_stamp;
  logic [PAYLOAD_BITS-1:0]       rd_payload;

  tmb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmb_ram #(
    .WIDTH (tmb_pkg::STAMP_BITS),
    .DEPTH (DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (stamp_us_i),
    .raddr_i (mem_raddr),
    .rdata_o (rd_stamp)
  );

  tmb_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (payload_in_i),
    .raddr_i (mem_raddr),
    .rdata_o (rd_payload)
  );

  tmb_ctrl #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .stamp_us_i       (stamp_us_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .match_stamp_us_o (match_stamp_us_o),
    .payload_out_o    (payload_out_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_raddr_o      (mem_raddr),
    .rd_stamp_i       (rd_stamp),
    .rd_payload_i     (rd_payload)
  );

endmodule

>>> dv/tmb_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmb_match_checker
// Watches the register port and both streams of the timestamp match buffer,
// keeps its own copy of the record ring, and compares every lookup result
// with the record that the ring predicts.
// ----------------------------------------------------------------------------
module tmb_match_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tmb_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [tmb_pkg::APB_DATA_BITS-1:0]     pwdata,
  input  logic                                  pready,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic                                  cmd_i,
  input  logic [tmb_pkg::STAMP_BITS-1:0]        stamp_us_i,
  input  logic [tmb_pkg::PAYLOAD_BITS_DEF-1:0]  payload_in_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic                                  found_i,
  input  logic [tmb_pkg::STAMP_BITS-1:0]        match_stamp_us_i,
  input  logic [tmb_pkg::PAYLOAD_BITS_DEF-1:0]  payload_out_i,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o
);
  import tmb_pkg::*;

  typedef struct packed {
    logic                          found;
    logic [STAMP_BITS-1:0]         stamp;
    logic [PAYLOAD_BITS_DEF-1:0]   payload;
  } match_t;

  logic [STAMP_BITS-1:0]       stamp_mem   [DEPTH_DEF];
  logic [PAYLOAD_BITS_DEF-1:0] payload_mem [DEPTH_DEF];
  int unsigned                 head;
  int unsigned                 entries;
  logic [LIMIT_BITS-1:0]       limit_q;
  logic [INTERVAL_BITS-1:0]    interval_q;
  match_t                      expected_matches [$];

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t ns: mismatch in %s: expected %h, got %h", $time, what, want, got);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic drop_oldest();
    if (entries > 0) begin
      head    = (head + 1) % DEPTH_DEF;
      entries = entries - 1;
    end
  endtask

  task automatic store_record(input logic [STAMP_BITS-1:0] stamp,
                              input logic [PAYLOAD_BITS_DEF-1:0] payload);
    int unsigned cap;
    int unsigned slot;
    bit          was_full;
    cap      = (32'(limit_q) > DEPTH_DEF) ? DEPTH_DEF : 32'(limit_q);
    was_full = (entries >= DEPTH_DEF);
    // A full ring makes room first; otherwise the limit is applied afterwards.
    if (was_full) drop_oldest();
    slot              = (head + entries) % DEPTH_DEF;
    stamp_mem[slot]   = stamp;
    payload_mem[slot] = payload;
    entries           = entries + 1;
    if (!was_full && entries > cap) drop_oldest();
  endtask

  task automatic lookup_record(input logic [STAMP_BITS-1:0] target);
    match_t m;
    bit     popped;
    bit     scanning;
    m        = '0;
    popped   = 1'b0;
    scanning = 1'b1;
    while (scanning && entries > 0) begin
      m.stamp   = stamp_mem[head];
      m.payload = payload_mem[head];
      if (m.stamp < target) begin
        drop_oldest();
        popped = 1'b1;
      end else begin
        m.found  = 1'b1;
        scanning = 1'b0;
      end
    end
    // Everything older was popped: the last one still matches if its lag is small.
    if (!m.found && popped && (target - m.stamp) <= {32'd0, interval_q})
      m.found = 1'b1;
    expected_matches.push_back(m);
  endtask

  task automatic check_match();
    match_t want;
    if (expected_matches.size() == 0) begin
      report_mismatch("result beat with no query pending", '0, match_stamp_us_i);
    end else begin
      want = expected_matches.pop_front();
      if (found_i !== want.found) report_mismatch("found", 64'(want.found), 64'(found_i));
      if (match_stamp_us_i !== want.stamp)
        report_mismatch("match_stamp_us", want.stamp, match_stamp_us_i);
      if (payload_out_i !== want.payload)
        report_mismatch("payload_out", want.payload, payload_out_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head         = 0;
      entries      = 0;
      limit_q      = MAX_ENTRIES_RST;
      interval_q   = INTERVAL_RST;
      fail_count_o = 0;
      pending_o    = 0;
      expected_matches.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_ENTRIES) limit_q = pwdata[LIMIT_BITS-1:0];
        else interval_q = pwdata[INTERVAL_BITS-1:0];
      end
      if (out_valid_i && out_ready_i) check_match();
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_PUSH) store_record(stamp_us_i, payload_in_i);
        else lookup_record(stamp_us_i);
      end
      pending_o = expected_matches.size();
    end
  end

endmodule

>>> dv/tb_timestamp_match_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_match_buffer
// Drives pushes and time queries into the timestamp match buffer under
// several limit and interval settings, with random gaps on both streams,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_timestamp_match_buffer;
  import tmb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = DEPTH_DEF + 10;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 213;
  localparam int unsigned RANDOM_ITEMS  = PHASES * PHASE_ITEMS;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          psel             = 1'b0;
  logic                          penable          = 1'b0;
  logic                          pwrite           = 1'b0;
  logic [APB_ADDR_BITS-1:0]      paddr            = '0;
  logic [APB_DATA_BITS-1:0]      pwdata           = '0;
  logic [APB_DATA_BITS-1:0]      prdata;
  logic                          pready;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic                          cmd_i            = CMD_PUSH;
  logic [STAMP_BITS-1:0]         stamp_us_i       = '0;
  logic [PAYLOAD_BITS_DEF-1:0]   payload_in_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic                          found_o;
  logic [STAMP_BITS-1:0]         match_stamp_us_o;
  logic [PAYLOAD_BITS_DEF-1:0]   payload_out_o;

  int unsigned                   fail_count;
  int unsigned                   pending_count;

  int unsigned                   send_idle_pct    = 0;
  int unsigned                   stall_pct        = 0;
  logic [INTERVAL_BITS-1:0]      interval_now     = INTERVAL_RST;
  logic [STAMP_BITS-1:0]         now_us           = '0;

  timestamp_match_buffer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .stamp_us_i       (stamp_us_i),
    .payload_in_i     (payload_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .match_stamp_us_o (match_stamp_us_o),
    .payload_out_o    (payload_out_o)
  );

  tmb_match_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .cmd_i            (cmd_i),
    .stamp_us_i       (stamp_us_i),
    .payload_in_i     (payload_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_i          (found_o),
    .match_stamp_us_i (match_stamp_us_o),
    .payload_out_i    (payload_out_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic write_reg(input logic reg_idx, input logic [APB_DATA_BITS-1:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic cmd, input logic [STAMP_BITS-1:0] stamp,
                           input logic [PAYLOAD_BITS_DEF-1:0] payload);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    stamp_us_i   = stamp;
    payload_in_i = payload;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // A push beat causes no result, so the last result does not mark the end of
  // the traffic; a settling wait follows before the registers are touched.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [LIMIT_BITS-1:0] limit,
                           input logic [INTERVAL_BITS-1:0] interval);
    wait_idle();
    write_reg(REG_MAX_ENTRIES, {24'd0, limit});
    write_reg(REG_INTERVAL, interval);
    interval_now = interval;
  endtask

  // Mostly in-order records with queries near the recent stamps; a few beats
  // carry arbitrary stamps to break the ordering.
  task automatic send_record_or_query(input int unsigned query_pct,
                                      input int unsigned lookback);
    logic [STAMP_BITS-1:0] target;
    if ($urandom_range(0, 99) < 6) begin
      send_beat(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
    end else if ($urandom_range(0, 99) < query_pct) begin
      case ($urandom_range(0, 3))
        0:       target = now_us - 64'($urandom_range(0, lookback));
        1:       target = now_us + 64'($urandom_range(0, 60000));
        2:       target = now_us + {32'd0, interval_now} + 64'($urandom_range(0, 1));
        default: target = now_us;
      endcase
      send_beat(CMD_QUERY, target, {$urandom, $urandom});
    end else begin
      now_us = now_us + 64'($urandom_range(1, 20000));
      send_beat(CMD_PUSH, now_us, {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [LIMIT_BITS-1:0]    limit;
    logic [INTERVAL_BITS-1:0] interval;
    int unsigned              query_pct;
    int unsigned              lookback;
    int unsigned              sent;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: empty ring, in-ring hits, lag right at and just past the interval.
    send_beat(CMD_QUERY, 64'd0, 64'd0);
    send_beat(CMD_PUSH, 64'd0, '1);
    send_beat(CMD_PUSH, 64'd100, 64'h0123_4567_89AB_CDEF);
    send_beat(CMD_QUERY, 64'd0, '1);
    send_beat(CMD_QUERY, 64'd50, 64'd0);
    send_beat(CMD_QUERY, 64'd40100, 64'd0);
    send_beat(CMD_QUERY, 64'd7, 64'd0);
    send_beat(CMD_PUSH, 64'd200, 64'd0);
    send_beat(CMD_QUERY, 64'd40201, 64'd0);

    // Widest interval and a limit above the ring size: a lag of 2^32 must miss.
    configure('1, '1);
    send_beat(CMD_PUSH, 64'd10, 64'h5555_5555_5555_5555);
    send_beat(CMD_QUERY, 64'h0000_0001_0000_000A, 64'd0);
    send_beat(CMD_PUSH, 64'd20, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(CMD_QUERY, 64'h0000_0001_0000_0013, 64'd0);
    send_beat(CMD_PUSH, '1, 64'hC3C3_3C3C_0FF0_F00F);
    send_beat(CMD_QUERY, '1, 64'd0);
    send_beat(CMD_QUERY, 64'd1, 64'd0);

    // Limit of zero: each push drops the oldest record again.
    configure('0, '0);
    send_beat(CMD_PUSH, 64'd5, 64'd1);
    send_beat(CMD_PUSH, 64'd6, 64'd2);
    send_beat(CMD_QUERY, 64'd6, 64'd0);
    send_beat(CMD_QUERY, 64'd7, 64'd0);

    now_us = {$urandom_range(0, 32'h3FFF_FFFF), $urandom};
    sent   = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin limit = 8'd255; interval = $urandom;             query_pct = 3;
                 lookback = 32'hF000_0000; end
        1: begin limit = 8'd3;   interval = '0;                   query_pct = 40;
                 lookback = 30000; end
        2: begin limit = 8'd128; interval = INTERVAL_RST;         query_pct = 30;
                 lookback = 200000; end
        3: begin limit = 8'd1;   interval = '1;                   query_pct = 40;
                 lookback = 50000; end
        4: begin limit = 8'd0;   interval = $urandom_range(0, 100000); query_pct = 35;
                 lookback = 50000; end
        5: begin limit = 8'd129; interval = 32'd20000;            query_pct = 10;
                 lookback = 2000000; end
        6: begin limit = 8'd64;  interval = $urandom_range(0, 100000); query_pct = 30;
                 lookback = 100000; end
        default: begin limit = MAX_ENTRIES_RST; interval = INTERVAL_RST; query_pct = 35;
                 lookback = 200000; end
      endcase
      configure(limit, interval);
      now_us = now_us + 64'($urandom_range(0, 32'hFFFF));
      repeat (PHASE_ITEMS) begin
        if (sent < RANDOM_ITEMS / 3) begin
          send_idle_pct = 8;
          stall_pct     = 70;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 70;
          stall_pct     = 8;
        end else begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        send_record_or_query(query_pct, lookback);
        sent = sent + 1;
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #25_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
